[hdl/chained_block_store_manager_top_assert.svh]
// Assertion macros shared by the checker of the chained block store manager.
`ifndef CHAINED_BLOCK_STORE_MANAGER_TOP_ASSERT_SVH
`define CHAINED_BLOCK_STORE_MANAGER_TOP_ASSERT_SVH
// Same-cycle implication, suspended during reset.
`define CBSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, suspended during reset.
`define CBSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// Next-cycle implication that also holds across reset.
`define CBSM_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

[hdl/cbsm_pkg.sv]
// Shared types and codes of the chained block store manager.
`default_nettype none
package cbsm_pkg;

  localparam int OFF_W = 16;
  localparam int ST_W  = 2;

  // Operation codes.
  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;
  localparam logic [1:0] FN_WRITE = 2'd3;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [ST_W-1:0] ST_BROKEN = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [OFF_W-1:0] word_offset;
  } in_beat_t;

  typedef struct packed {
    logic [OFF_W-1:0] result_offset;
    logic [ST_W-1:0]  status;
  } out_beat_t;

endpackage
`default_nettype wire

[hdl/chained_block_store_manager_top.sv]
// Top level of the chained block store manager: sequencer around the link table.
`default_nettype none
// Keeps one link-table entry per storage block (free, end of chain, or link to
// the next block) and runs one operation per input beat: allocate the lowest
// free block, free a chain, or advance a read or write pointer by one word.
// Exactly one result beat follows each input beat. The block works on one item
// at a time and drops in_ready from acceptance until the result is loaded into
// the output register; a waiting result does not stop the next acceptance.
// After reset a clearing pass writes every table entry free, with in_ready low.
// The time per item, accept to next accept, is set by the single table RAM
// port, with which entries are visited one at a time, and by the
// reciprocal-multiply divider:
//   allocate:      scans entries from the lowest-free hint, and goes straight
//                  to the result when the hint already shows every block taken
//   free chain:    walks the chain and frees each entry; nothing outside the store
//   advance:       divides only, inside a block or outside the store; reads the
//                  link across a block boundary (also on a broken chain), and scans
//                  for a free block when a write pointer runs off the end of its chain.
// An item also waits for the output register to be taken.
// The hint keeps the lowest index that may be free, so back-to-back
// allocations scan about one entry each.
module chained_block_store_manager_top #(
  parameter int NUM_BLOCKS  = 256,
  parameter int BLOCK_WORDS = 128,
  parameter int BASE_WORDS  = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cbsm_pkg::in_beat_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output cbsm_pkg::out_beat_t       out_data
);

  localparam int IW    = $clog2(NUM_BLOCKS);
  localparam int HW    = $clog2(NUM_BLOCKS + 1);
  localparam int EW    = $clog2(NUM_BLOCKS + 2);
  localparam int OW    = cbsm_pkg::OFF_W;
  localparam int REM_W = $clog2(BLOCK_WORDS) + 1;

  // Link table entry codes.
  localparam logic [EW-1:0] ENT_FREE = '0;
  localparam logic [EW-1:0] ENT_END  = EW'(1);
  localparam logic [EW-1:0] ENT_BIAS = EW'(2);

  localparam logic [IW-1:0]    LAST_BLK = IW'(NUM_BLOCKS - 1);
  localparam logic [HW-1:0]    HINT_ALL = HW'(NUM_BLOCKS);
  localparam logic [EW-1:0]    ENT_NUM  = EW'(NUM_BLOCKS);
  localparam logic [OW-1:0]    QUOT_NUM = OW'(NUM_BLOCKS);
  localparam logic [REM_W-1:0] REM_LAST = REM_W'(BLOCK_WORDS - 1);
  localparam logic [OW+1:0]    BASE_X   = (OW + 2)'(BASE_WORDS);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_DIV      = 13'b0000000000100,
    S_FREE_RD  = 13'b0000000001000,
    S_FREE_UPD = 13'b0000000010000,
    S_ADV_RD   = 13'b0000000100000,
    S_ADV_CHK  = 13'b0000001000000,
    S_SCAN_RD  = 13'b0000010000000,
    S_SCAN_CHK = 13'b0000100000000,
    S_LINK     = 13'b0001000000000,
    S_START    = 13'b0010000000000,
    S_DONE     = 13'b0100000000000,
    S_SPARE    = 13'b1000000000000
  } state_t;

  state_t                 state;
  logic [1:0]             func;
  logic [OW-1:0]          offset;
  logic                   base_ok;
  logic [IW-1:0]          cur;
  logic [IW-1:0]          scan_idx;
  logic [IW-1:0]          new_blk;
  logic [IW-1:0]          walk_cnt;
  logic [IW-1:0]          clr_idx;
  logic [HW-1:0]          hint;
  logic [OW-1:0]          res_off;
  logic [cbsm_pkg::ST_W-1:0] res_st;

  // Table RAM port.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ent;

  // Divider.
  logic             div_start;
  logic [OW+1:0]    off_x;
  logic [OW+1:0]    diff;
  logic             div_done;
  logic [OW-1:0]    quot;
  logic [REM_W-1:0] rem;

  logic             in_fire;
  logic             in_range;
  logic [EW-1:0]    link_x;
  logic             ent_link;
  logic [IW-1:0]    link_blk;
  logic [31:0]      start_x;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Offset relative to the store base; the divider sees it for every non-allocate beat.
  assign off_x     = {2'b00, in_data.word_offset};
  assign diff      = off_x - BASE_X;
  assign div_start = in_fire && (in_data.func != cbsm_pkg::FN_ALLOC);

  cbsm_divu #(
    .DIVISOR (BLOCK_WORDS)
  ) u_divu (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff[OW-1:0]),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  assign in_range = base_ok && (quot < QUOT_NUM);

  // Decode the entry just read.
  assign link_x   = ent - ENT_BIAS;
  assign ent_link = (ent >= ENT_BIAS) && (link_x < ENT_NUM);
  assign link_blk = link_x[IW-1:0];

  assign start_x = 32'(BASE_WORDS) + 32'(new_blk) * 32'(BLOCK_WORDS);

  cbsm_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ent)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = ENT_FREE;
    ram_raddr = cur;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
      end
      S_FREE_UPD: begin
        ram_we = 1'b1;
      end
      S_SCAN_RD: begin
        ram_raddr = scan_idx;
      end
      S_SCAN_CHK: begin
        ram_we    = (ent == ENT_FREE);
        ram_waddr = scan_idx;
        ram_wdata = ENT_END;
      end
      S_LINK: begin
        ram_we    = 1'b1;
        ram_wdata = EW'(new_blk) + ENT_BIAS;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      hint      <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken; a new load below overrides.
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_BLK) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            func    <= in_data.func;
            offset  <= in_data.word_offset;
            base_ok <= (off_x >= BASE_X);
            if (in_data.func == cbsm_pkg::FN_ALLOC) begin
              scan_idx <= hint[IW-1:0];
              if (hint == HINT_ALL) begin
                res_off <= '0;
                res_st  <= cbsm_pkg::ST_NOFREE;
                state   <= S_DONE;
              end else begin
                state <= S_SCAN_RD;
              end
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            cur      <= quot[IW-1:0];
            walk_cnt <= '0;
            res_off  <= '0;
            res_st   <= cbsm_pkg::ST_OK;
            if (func == cbsm_pkg::FN_FREE) begin
              state <= in_range ? S_FREE_RD : S_DONE;
            end else if (!in_range) begin
              res_st <= cbsm_pkg::ST_BROKEN;
              state  <= S_DONE;
            end else if (rem != REM_LAST) begin
              res_off <= offset + 1'b1;
              state   <= S_DONE;
            end else begin
              state <= S_ADV_RD;
            end
          end
        end
        S_FREE_RD: begin
          state <= S_FREE_UPD;
        end
        S_FREE_UPD: begin
          // Entry at cur is cleared by the RAM write this cycle.
          if (HW'(cur) < hint) begin
            hint <= HW'(cur);
          end
          if (ent_link && (walk_cnt != LAST_BLK)) begin
            cur      <= link_blk;
            walk_cnt <= walk_cnt + 1'b1;
            state    <= S_FREE_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_ADV_RD: begin
          state <= S_ADV_CHK;
        end
        S_ADV_CHK: begin
          scan_idx <= hint[IW-1:0];
          if (ent_link) begin
            new_blk <= link_blk;
            state   <= S_START;
          end else if ((ent == ENT_END) && (func == cbsm_pkg::FN_WRITE)) begin
            if (hint == HINT_ALL) begin
              res_st <= cbsm_pkg::ST_NOFREE;
              state  <= S_DONE;
            end else begin
              state <= S_SCAN_RD;
            end
          end else begin
            res_st <= cbsm_pkg::ST_BROKEN;
            state  <= S_DONE;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (ent == ENT_FREE) begin
            // Everything below the taken block is in use.
            hint    <= HW'(scan_idx) + 1'b1;
            new_blk <= scan_idx;
            state   <= (func == cbsm_pkg::FN_WRITE) ? S_LINK : S_START;
          end else if (scan_idx == LAST_BLK) begin
            res_off <= '0;
            res_st  <= cbsm_pkg::ST_NOFREE;
            state   <= S_DONE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            state    <= S_SCAN_RD;
          end
        end
        S_LINK: begin
          state <= S_START;
        end
        S_START: begin
          res_off <= start_x[OW-1:0];
          res_st  <= cbsm_pkg::ST_OK;
          state   <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid || out_ready) begin
            out_valid              <= 1'b1;
            out_data.result_offset <= res_off;
            out_data.status        <= res_st;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/cbsm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cbsm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/cbsm_divu.sv]
// Divider of a word offset by the constant block size, by reciprocal multiplication.
`default_nettype none
module cbsm_divu #(
  parameter int DIVISOR = 128,
  localparam int REM_W = $clog2(DIVISOR) + 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [cbsm_pkg::OFF_W-1:0]  dividend,
  output logic                             done,
  output logic      [cbsm_pkg::OFF_W-1:0]  quot,
  output logic      [REM_W-1:0]            rem
);

  localparam int OW = cbsm_pkg::OFF_W;
  // Reciprocal rounded up at a scale of 2^(OW + ceil(log2 DIVISOR)); the shifted
  // product is the exact quotient for every OW-bit dividend.
  localparam int SH = OW + $clog2(DIVISOR);
  localparam int MW = OW + 1;
  localparam int PW = OW + MW;
  localparam longint RECIP_FULL =
    ((longint'(1) << SH) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_FULL);
  localparam logic [MW-1:0] DIV   = MW'(DIVISOR);

  logic          p_quot;
  logic          p_rem;
  logic [OW-1:0] dreg;
  logic [OW-1:0] mul_a;
  logic [MW-1:0] mul_b;
  logic [PW-1:0] prod;

  // One multiplier: dividend times reciprocal first, then quotient times divisor.
  assign mul_a = p_quot ? dreg : quot;
  assign mul_b = p_quot ? RECIP : DIV;
  assign prod  = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_quot <= 1'b0;
      p_rem  <= 1'b0;
      done   <= 1'b0;
    end else begin
      p_quot <= start;
      p_rem  <= p_quot;
      done   <= p_rem;
      if (start) begin
        dreg <= dividend;
      end
      if (p_quot) begin
        quot <= OW'(prod >> SH);
      end
      if (p_rem) begin
        rem <= REM_W'(dreg - prod[OW-1:0]);
      end
    end
  end

endmodule
`default_nettype wire

[hdl/cbsm_checker.sv]
// Port-level checker for the chained block store manager, bound to the top level.
`default_nettype none
`include "chained_block_store_manager_top_assert.svh"
module cbsm_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire cbsm_pkg::out_beat_t out_data
);

  `CBSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")
  `CBSM_ASSERT_NOW(a_fail_zero, out_valid && (out_data.status != cbsm_pkg::ST_OK), out_data.result_offset == '0, "failed result carries a nonzero offset")
  `CBSM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while an item is in progress")
  `CBSM_ASSERT_NEXT_RST(a_reset_clear, rst, !out_valid && !in_ready, "block ready or showing a result right after reset")

endmodule

bind chained_block_store_manager_top cbsm_checker u_cbsm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
